[rtl/core/gse_pkg.sv]
package gse_pkg;

	// Width of the divisor and of the partial remainder
	localparam int DIV_BITS = 16;
	// Width of the code length field
	localparam int LEN_BITS = 17;

	typedef enum logic [1:0] {
		CFG_DIVISOR   = 2'd0,
		CFG_RICE_MODE = 2'd1,
		CFG_RICE_BITS = 2'd2
	} cfg_idx_t;

	// Encoder settings, derived once per register write
	typedef struct packed {
		logic [DIV_BITS-1:0] divisor;   // zero already mapped to one
		logic [4:0]          k;         // ceil(log2(divisor))
		logic [DIV_BITS-1:0] u;         // 2^k - divisor
		logic                rice_mode;
		logic [4:0]          rice_len;  // saturated to DIV_BITS
	} enc_cfg_t;

	// Smallest k with 2^k >= d, for d >= 1: bit length of d - 1
	function automatic logic [4:0] clog2_div(input logic [DIV_BITS-1:0] d);
		logic [DIV_BITS-1:0] v;
		logic [4:0]          k;
		v = d - DIV_BITS'(1);
		k = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			if (v[i]) begin
				k = 5'(i + 1);
			end
		end
		return k;
	endfunction

endpackage

[rtl/core/gse_divider.sv]
module gse_divider
	import gse_pkg::*;
#(
	parameter int WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [DIV_BITS-1:0] divisor,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [WIDTH-1:0]    dividend,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [WIDTH-1:0]    quo,
	output logic [DIV_BITS-1:0] rem
);

	// One restoring step per stage, MSB of the dividend first
	logic                vld_s [WIDTH];
	logic [DIV_BITS-1:0] rem_s [WIDTH];
	logic [WIDTH-1:0]    quo_s [WIDTH];
	logic [WIDTH-1:0]    dvd_s [WIDTH];
	logic                rdy   [WIDTH+1];

	assign rdy[WIDTH] = out_ready;
	assign in_ready   = rdy[0];

	for (genvar j = 0; j < WIDTH; j++) begin : g_stage
		logic                vld_in;
		logic [DIV_BITS-1:0] rem_in;
		logic [WIDTH-1:0]    quo_in;
		logic [WIDTH-1:0]    dvd_in;
		logic [DIV_BITS:0]   trial;
		logic [DIV_BITS:0]   diff;
		logic                ge;

		if (j == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = '0;
			assign quo_in = '0;
			assign dvd_in = dividend;
		end else begin : g_next
			assign vld_in = vld_s[j-1];
			assign rem_in = rem_s[j-1];
			assign quo_in = quo_s[j-1];
			assign dvd_in = dvd_s[j-1];
		end

		assign trial = {rem_in, dvd_in[WIDTH-1]};
		assign diff  = trial - {1'b0, divisor};
		assign ge    = trial >= {1'b0, divisor};

		assign rdy[j] = !vld_s[j] || rdy[j+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && vld_in) begin
				rem_s[j] <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
				quo_s[j] <= {quo_in[WIDTH-2:0], ge};
				dvd_s[j] <= {dvd_in[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[WIDTH-1];
	assign quo       = quo_s[WIDTH-1];
	assign rem       = rem_s[WIDTH-1];

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rem < divisor)
		else $error("divider remainder not below divisor");
`endif

endmodule

[rtl/core/golomb_symbol_encoder.sv]
// A symbol passes through the divider stages and then the registered output stage.
// Throughput: one symbol per cycle unless out_ready stalls; the divider resolves one quotient bit per stage.
// Each stage holds its beat only while the stage after it is full and stalled.
// Reset clears all valid bits and loads divisor 1, rice_mode 0, rice_bits 0.
// Configuration writes take effect at once; cfg_ready is always high.
module golomb_symbol_encoder
	import gse_pkg::*;
#(
	parameter int SYMBOL_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [DIV_BITS-1:0]    cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SYMBOL_BITS-1:0] symbol,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [15:0]            quotient,
	output logic [15:0]            remainder_code,
	output logic [4:0]             remainder_length,
	output logic [LEN_BITS-1:0]    code_length
);

	enc_cfg_t            cfg_q;
	logic [DIV_BITS-1:0] wr_div;
	logic [4:0]          wr_k;
	logic [DIV_BITS:0]   wr_pow;

	assign cfg_ready = 1'b1;

	always_comb begin
		wr_div = (cfg_data == '0) ? DIV_BITS'(1) : cfg_data;
		wr_k   = clog2_div(wr_div);
		wr_pow = (DIV_BITS+1)'(1) << wr_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.divisor   <= DIV_BITS'(1);
			cfg_q.k         <= '0;
			cfg_q.u         <= '0;
			cfg_q.rice_mode <= 1'b0;
			cfg_q.rice_len  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DIVISOR: begin
					cfg_q.divisor <= wr_div;
					cfg_q.k       <= wr_k;
					cfg_q.u       <= DIV_BITS'(wr_pow - {1'b0, wr_div});
				end
				CFG_RICE_MODE: begin
					cfg_q.rice_mode <= cfg_data[0];
				end
				CFG_RICE_BITS: begin
					cfg_q.rice_len <= (cfg_data[4:0] > 5'(DIV_BITS)) ? 5'(DIV_BITS)
						: cfg_data[4:0];
				end
				default: begin
				end
			endcase
		end
	end

	logic                   dv_valid;
	logic                   dv_ready;
	logic [SYMBOL_BITS-1:0] dv_quo;
	logic [DIV_BITS-1:0]    dv_rem;

	gse_divider #(
		.WIDTH(SYMBOL_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.divisor  (cfg_q.divisor),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.dividend (symbol),
		.out_valid(dv_valid),
		.out_ready(dv_ready),
		.quo      (dv_quo),
		.rem      (dv_rem)
	);

	// Remainder coding stage
	logic [DIV_BITS-1:0] enc_code;
	logic [4:0]          enc_len;
	logic [DIV_BITS:0]   rice_mask;

	always_comb begin
		rice_mask = ((DIV_BITS+1)'(1) << cfg_q.rice_len) - (DIV_BITS+1)'(1);
		if (cfg_q.divisor == DIV_BITS'(1)) begin
			enc_code = '0;
			enc_len  = '0;
		end else if (cfg_q.rice_mode) begin
			enc_code = dv_rem & rice_mask[DIV_BITS-1:0];
			enc_len  = cfg_q.rice_len;
		end else if (dv_rem < cfg_q.u) begin
			// short codeword: k-1 bits
			enc_code = dv_rem;
			enc_len  = cfg_q.k - 5'd1;
		end else begin
			enc_code = dv_rem + cfg_q.u;
			enc_len  = cfg_q.k;
		end
	end

	logic                out_vld_s;
	logic [15:0]         quo_so;
	logic [15:0]         code_so;
	logic [4:0]          rlen_so;
	logic [LEN_BITS-1:0] clen_so;

	assign dv_ready = !out_vld_s || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s <= 1'b0;
		end else if (dv_ready) begin
			out_vld_s <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready && dv_valid) begin
			quo_so  <= 16'(dv_quo);
			code_so <= 16'(enc_code);
			rlen_so <= enc_len;
			clen_so <= LEN_BITS'(dv_quo) + LEN_BITS'(1) + LEN_BITS'(enc_len);
		end
	end

	assign out_valid        = out_vld_s;
	assign quotient         = quo_so;
	assign remainder_code   = code_so;
	assign remainder_length = rlen_so;
	assign code_length      = clen_so;

`ifndef SYNTHESIS
	a_code_fits_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (remainder_code >> remainder_length) == '0)
		else $error("remainder code wider than its length");

	a_unary_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cfg_q.divisor == DIV_BITS'(1) |-> remainder_length == '0)
		else $error("remainder present with divisor one");

	a_tb_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cfg_q.rice_mode && cfg_q.divisor != DIV_BITS'(1)
		|-> remainder_length == cfg_q.k || remainder_length == cfg_q.k - 5'd1)
		else $error("truncated binary length out of range");
`endif

endmodule
